// File: sv/ffpr_pkg.sv
package ffpr_pkg;

	localparam int FRAME_BYTES = 60;
	localparam int POS_W       = 6;
	localparam int ADDR_W      = 7;
	localparam int MEM_DEPTH   = 2 * FRAME_BYTES;

	// byte positions inside a frame
	localparam logic [POS_W-1:0] POS_FIRST_FIELD = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LAST_FIELD  = POS_W'(57);
	localparam logic [POS_W-1:0] POS_TRAILER     = POS_W'(FRAME_BYTES - 1);
	localparam logic [ADDR_W-1:0] SLOT1_BASE     = ADDR_W'(FRAME_BYTES);

	// register indexes
	localparam logic [1:0] REG_HEADER  = 2'd0;
	localparam logic [1:0] REG_TRAILER = 2'd1;
	localparam logic [1:0] REG_LE      = 2'd2;

	localparam logic [7:0] HEADER_RST  = 8'hA5;
	localparam logic [7:0] TRAILER_RST = 8'h5A;

	// field kinds
	localparam logic [1:0] KIND_SWITCH = 2'd0;
	localparam logic [1:0] KIND_INT16  = 2'd1;
	localparam logic [1:0] KIND_FLOAT  = 2'd2;

	localparam logic [3:0] FLD_SWITCH    = 4'd0;
	localparam logic [3:0] FLD_FIRST_FLT = 4'd3;
	localparam logic [3:0] FLD_LAST      = 4'd15;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	// one finished frame waiting for the back end
	typedef struct packed {
		logic slot;
		logic le;
	} frame_desc_t;

	typedef struct packed {
		logic en;
		logic slot;
	} slot_free_t;

endpackage

// File: sv/ffpr_front.sv
module ffpr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           header_byte,
	input  logic [7:0]           trailer_byte,
	input  logic                 little_endian,
	output ffpr_pkg::mem_wr_t     mem_wr,
	output logic                 push,
	output ffpr_pkg::frame_desc_t push_desc,
	input  ffpr_pkg::slot_free_t  slot_free
);
	import ffpr_pkg::*;

	logic [POS_W-1:0] cnt_q;
	logic [7:0]       byte0_q;
	logic             wr_slot_q;
	logic [1:0]       busy_q;
	logic             acc;
	logic             drop;
	logic             frame_end;

	// a slot stays busy from frame end until the back end has read it out
	assign rx_ready  = !busy_q[wr_slot_q];
	assign acc       = rx_valid && rx_ready;
	assign drop      = (cnt_q == '0) && (rx_byte != header_byte);
	assign frame_end = acc && !drop && (cnt_q == POS_TRAILER);
	// header rechecked against the current register value at frame end
	assign push      = frame_end && (byte0_q == header_byte) && (rx_byte == trailer_byte);

	assign push_desc.slot = wr_slot_q;
	assign push_desc.le   = little_endian;

	assign mem_wr.en   = acc && !drop;
	assign mem_wr.addr = ADDR_W'(cnt_q) + (wr_slot_q ? SLOT1_BASE : '0);
	assign mem_wr.data = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			wr_slot_q <= 1'b0;
			busy_q    <= '0;
		end else begin
			if (acc && !drop) begin
				if (cnt_q == POS_TRAILER) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + POS_W'(1);
				end
			end
			if (push) begin
				wr_slot_q <= !wr_slot_q;
			end
			for (int s = 0; s < 2; s++) begin
				if (push && (wr_slot_q == s[0])) begin
					busy_q[s] <= 1'b1;
				end else if (slot_free.en && (slot_free.slot == s[0])) begin
					busy_q[s] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !drop && (cnt_q == '0)) begin
			byte0_q <= rx_byte;
		end
	end

endmodule

// File: sv/ffpr_queue.sv
module ffpr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ffpr_pkg::frame_desc_t push_desc,
	output logic                  pop_valid,
	output ffpr_pkg::frame_desc_t pop_desc,
	input  logic                  pop
);
	import ffpr_pkg::*;

	// two entries: at most two slots can be busy, so it never overflows
	frame_desc_t ent_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;

	assign pop_valid = (cnt_q != '0);
	assign pop_desc  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_desc;
		end
	end

endmodule

// File: sv/ffpr_back.sv
module ffpr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ffpr_pkg::mem_wr_t     mem_wr,
	input  logic                  desc_valid,
	input  ffpr_pkg::frame_desc_t desc,
	output logic                  pop,
	output ffpr_pkg::slot_free_t  slot_free,
	output logic                  field_valid,
	input  logic                  field_ready,
	output logic [3:0]            field_index,
	output logic [1:0]            field_kind,
	output logic [31:0]           field_value,
	output logic                  last_field
);
	import ffpr_pkg::*;

	localparam logic BK_IDLE = 1'b0;
	localparam logic BK_RUN  = 1'b1;

	logic [7:0]        mem [MEM_DEPTH];
	logic [7:0]        rdata_q;
	logic              state_q;
	logic              slot_q;
	logic              le_q;
	logic [POS_W-1:0]  pos_q;
	logic [3:0]        fld_q;
	logic [1:0]        bif_q;
	logic [31:0]       acc_q;
	logic              out_valid_q;

	logic [1:0]        nbytes_m1;
	logic [1:0]        lane;
	logic [31:0]       new_val;
	logic              field_end;
	logic              out_free;
	logic              advance;
	logic              last_byte;
	logic              rd_en;
	logic [POS_W-1:0]  rd_pos;
	logic              rd_slot;
	logic [ADDR_W-1:0] rd_addr;

	always_comb begin
		nbytes_m1 = (fld_q == FLD_SWITCH) ? 2'd0 : ((fld_q < FLD_FIRST_FLT) ? 2'd1 : 2'd3);
		lane      = le_q ? bif_q : (nbytes_m1 - bif_q);
		new_val   = (bif_q == '0) ? '0 : acc_q;
		new_val[{lane, 3'b000} +: 8] = rdata_q;
	end

	assign field_end = (bif_q == nbytes_m1);
	assign out_free  = !out_valid_q || field_ready;
	assign advance   = (state_q == BK_RUN) && (!field_end || out_free);
	assign last_byte = (pos_q == POS_LAST_FIELD);

	assign pop     = (state_q == BK_IDLE) && desc_valid;
	assign rd_en   = pop || (advance && !last_byte);
	assign rd_pos  = (state_q == BK_IDLE) ? POS_FIRST_FIELD : (pos_q + POS_W'(1));
	assign rd_slot = (state_q == BK_IDLE) ? desc.slot : slot_q;
	assign rd_addr = ADDR_W'(rd_pos) + (rd_slot ? SLOT1_BASE : '0);

	assign slot_free.en   = advance && last_byte;
	assign slot_free.slot = slot_q;
	assign field_valid    = out_valid_q;

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[mem_wr.addr] <= mem_wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				state_q <= BK_RUN;
			end else if (advance && last_byte) begin
				state_q <= BK_IDLE;
			end
			if (advance && field_end) begin
				out_valid_q <= 1'b1;
			end else if (field_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot_q <= desc.slot;
			le_q   <= desc.le;
			pos_q  <= POS_FIRST_FIELD;
			fld_q  <= FLD_SWITCH;
			bif_q  <= '0;
		end else if (advance) begin
			pos_q <= pos_q + POS_W'(1);
			acc_q <= new_val;
			if (field_end) begin
				fld_q <= fld_q + 4'd1;
				bif_q <= '0;
			end else begin
				bif_q <= bif_q + 2'd1;
			end
		end
		if (advance && field_end) begin
			field_index <= fld_q;
			field_kind  <= (fld_q == FLD_SWITCH) ? KIND_SWITCH :
				((fld_q < FLD_FIRST_FLT) ? KIND_INT16 : KIND_FLOAT);
			field_value <= new_val;
			last_field  <= (fld_q == FLD_LAST);
		end
	end

endmodule

// File: sv/fixed_frame_parameter_receiver_top.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+----------------------------------------------
// rx        | rx_valid / rx_ready     | rx_byte[7:0]
// field     | field_valid/field_ready | field_index, field_kind, field_value, last_field
// cfg       | cfg_we (no wait)        | cfg_index[1:0], cfg_wdata[7:0]
//
// One rx byte per cycle while rx_ready is high. A good frame is read back out of
// the frame RAM one byte per cycle while field_ready stays high: the pop of its
// descriptor starts the read, then the 57 field bytes give the 16 fields of a frame.
// The RAM holds two frame slots; rx_ready drops only when the slot being filled
// is still waiting to be read out, i.e. when the readout falls a whole frame behind.
// field_ready low freezes the readout at the next field boundary.
// arst_n clears counters, slot flags, queue and config registers; the RAM is not cleared.
module fixed_frame_parameter_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        field_valid,
	input  logic        field_ready,
	output logic [3:0]  field_index,
	output logic [1:0]  field_kind,
	output logic [31:0] field_value,
	output logic        last_field,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);
	import ffpr_pkg::*;

	logic [7:0]  header_q;
	logic [7:0]  trailer_q;
	logic        le_q;

	mem_wr_t     mem_wr;
	logic        push;
	frame_desc_t push_desc;
	logic        desc_valid;
	frame_desc_t desc;
	logic        pop;
	slot_free_t  slot_free;

	// config registers; index 3 is not a register and is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RST;
			trailer_q <= TRAILER_RST;
			le_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER:  header_q  <= cfg_wdata;
				REG_TRAILER: trailer_q <= cfg_wdata;
				REG_LE:      le_q      <= cfg_wdata[0];
				default:     ;
			endcase
		end
	end

	// front: header hunt, byte count, RAM write, frame check
	ffpr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_ready      (rx_ready),
		.rx_byte       (rx_byte),
		.header_byte   (header_q),
		.trailer_byte  (trailer_q),
		.little_endian (le_q),
		.mem_wr        (mem_wr),
		.push          (push),
		.push_desc     (push_desc),
		.slot_free     (slot_free)
	);

	// finished frames (slot + byte order latched at the last byte)
	ffpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop_valid (desc_valid),
		.pop_desc  (desc),
		.pop       (pop)
	);

	// back: frame RAM, field assembly, output register
	ffpr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mem_wr      (mem_wr),
		.desc_valid  (desc_valid),
		.desc        (desc),
		.pop         (pop),
		.slot_free   (slot_free),
		.field_valid (field_valid),
		.field_ready (field_ready),
		.field_index (field_index),
		.field_kind  (field_kind),
		.field_value (field_value),
		.last_field  (last_field)
	);

endmodule

// File: tb/sv/fixed_frame_parameter_receiver_top_test.sv
module fixed_frame_parameter_receiver_top_test;
	import ffpr_pkg::*;

	// field layout inside a 60-byte frame
	localparam int SWITCH_POS       = 1;
	localparam int INT_BASE         = 2;
	localparam int FLOAT_BASE       = 6;
	localparam int FIELDS_PER_FRAME = 16;

	// cfg index with no register behind it
	localparam logic [1:0] REG_NONE = 2'd3;

	localparam int SETTLE_CYCLES = 120;    // full readout of a frame plus margin
	localparam int LONG_HOLD     = 700;    // field_ready low long enough to back up rx
	localparam int RANDOM_ITEMS  = 120;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [3:0]  index;
		logic [1:0]  kind;
		logic [31:0] value;
		logic        last;
	} param_field_t;

	typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_RAMP} fill_t;
	typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_STARVED} stall_mode_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        rx_valid    = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte     = 8'h00;
	logic        field_valid;
	logic        field_ready = 1'b0;
	logic [3:0]  field_index;
	logic [1:0]  field_kind;
	logic [31:0] field_value;
	logic        last_field;
	logic        cfg_we      = 1'b0;
	logic [1:0]  cfg_index   = REG_HEADER;
	logic [7:0]  cfg_wdata   = 8'h00;

	fixed_frame_parameter_receiver_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.field_valid (field_valid),
		.field_ready (field_ready),
		.field_index (field_index),
		.field_kind  (field_kind),
		.field_value (field_value),
		.last_field  (last_field),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	// ------------------------------------------------------------------
	// Deframer shadow: its own copy of the registers and the frame store
	// ------------------------------------------------------------------
	logic [7:0]       hdr_cfg;
	logic [7:0]       trl_cfg;
	logic             le_cfg;
	logic [7:0]       frame_buf [FRAME_BYTES];
	logic [POS_W-1:0] frame_pos;

	param_field_t pending_fields[$];   // fields the block still owes us
	logic [7:0]   tx_bytes[$];         // rx bytes not yet offered to the block

	int  errors       = 0;
	int  queued_items = 0;
	int  cycle_count  = 0;
	bit  rx_hs        = 1'b0;          // rx transaction at the last rising edge
	bit  sender_steady = 1'b0;         // no gaps from the sender while set
	int  hold_kick    = 0;             // bumped to ask the receiver for a long hold

	// Multi-byte field assembly; byte order is whatever is in force at frame end.
	function automatic logic [31:0] join_bytes(input int off, input int nbytes);
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < nbytes; i++) begin
			if (le_cfg)
				v |= 32'(frame_buf[off + i]) << (8 * i);
			else
				v = (v << 8) | 32'(frame_buf[off + i]);
		end
		return v;
	endfunction

	// One accepted rx byte. Queues 16 fields when a frame closes with a good
	// header and trailer; a bad frame just drops and the count restarts at 0.
	task automatic deframe_byte(input logic [7:0] b);
		param_field_t f;
		if (frame_pos == 0 && b != hdr_cfg)
			return;
		frame_buf[frame_pos] = b;
		frame_pos++;
		if (frame_pos < FRAME_BYTES)
			return;
		frame_pos = '0;
		// header is checked again against the register as it is now
		if (frame_buf[0] != hdr_cfg || frame_buf[FRAME_BYTES - 1] != trl_cfg)
			return;
		for (int k = 0; k < FIELDS_PER_FRAME; k++) begin
			f.index = 4'(k);
			f.last  = (4'(k) == FLD_LAST);
			if (4'(k) == FLD_SWITCH) begin
				f.kind  = KIND_SWITCH;
				f.value = {24'd0, frame_buf[SWITCH_POS]};
			end else if (4'(k) < FLD_FIRST_FLT) begin
				f.kind  = KIND_INT16;
				f.value = join_bytes(INT_BASE + 2 * (k - 1), 2);
			end else begin
				f.kind  = KIND_FLOAT;
				f.value = join_bytes(FLOAT_BASE + 4 * (k - int'(FLD_FIRST_FLT)), 4);
			end
			pending_fields.push_back(f);
		end
	endtask

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// rx side: acceptance feeds the shadow; driver changes at the falling edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rx_hs = rx_valid && rx_ready;
		if (rx_hs)
			deframe_byte(rx_byte);
	end

	int burst_left = 0;
	int gap_left   = 0;

	// Bursts of random length, random gaps in between; some bursts carry no gap
	// at all, and now and then a long pause lands mid-frame.
	always @(negedge clk) begin
		if (!rx_valid || rx_hs) begin
			if (gap_left > 0 && !sender_steady) begin
				gap_left--;
				rx_valid <= 1'b0;
			end else if (tx_bytes.size() != 0) begin
				rx_valid <= 1'b1;
				rx_byte  <= tx_bytes.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					if ($urandom_range(0, 15) == 0)
						gap_left = 40;
				end
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// field side: receiver stall pattern picks its own mode every so often;
	// a hold request overrides it and keeps field_ready low over the hold cycles
	// ------------------------------------------------------------------
	stall_mode_t ready_mode = RDY_ALWAYS;
	int          mode_left  = 0;
	int          hold_left  = 0;
	int          hold_seen  = 0;
	int          beat       = 0;

	always @(negedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen = hold_kick;
			hold_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			ready_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left  = $urandom_range(64, 256);
		end else begin
			mode_left--;
		end
		beat++;
		if (hold_left > 0) begin
			hold_left--;
			field_ready <= 1'b0;
		end else begin
			case (ready_mode)
				RDY_ALWAYS:   field_ready <= 1'b1;
				RDY_RANDOM:   field_ready <= ($urandom_range(0, 2) != 0);
				RDY_PERIODIC: field_ready <= ((beat % 7) < 4);
				default:      field_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Field checker
	// ------------------------------------------------------------------
	function automatic void check_one(input string what, input logic [31:0] want,
	                                  input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin : field_check
		param_field_t want;
		if (field_valid && field_ready) begin
			if (pending_fields.size() == 0) begin
				errors++;
				$display("%0t: field with nothing expected, expected none, got idx %0d kind %0d value %h last %0d",
				         $time, field_index, field_kind, field_value, last_field);
			end else begin
				want = pending_fields.pop_front();
				check_one("field_index", 32'(want.index), 32'(field_index));
				check_one("field_kind",  32'(want.kind),  32'(field_kind));
				check_one("field_value", want.value,      field_value);
				check_one("last_field",  32'(want.last),  32'(last_field));
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d fields still expected",
		         $time, cycle_count, pending_fields.size());
		$display("fixed_frame_parameter_receiver_top_test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Register write; only called with nothing in flight, so the shadow
	// can follow right away.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HEADER:  hdr_cfg = val;
			REG_TRAILER: trl_cfg = val;
			REG_LE:      le_cfg  = val[0];
			default: ;
		endcase
	endtask

	// Bytes lo..hi of a frame built on the current header/trailer registers.
	task automatic push_frame(input fill_t fill, input bit good_trailer,
	                          input int lo, input int hi);
		logic [7:0] b;
		for (int i = lo; i <= hi; i++) begin
			if (i == 0)
				b = hdr_cfg;
			else if (i == FRAME_BYTES - 1)
				b = good_trailer ? trl_cfg : trl_cfg ^ 8'($urandom_range(1, 255));
			else begin
				case (fill)
					FILL_ONES:  b = 8'hFF;
					FILL_ZEROS: b = 8'h00;
					FILL_RAMP:  b = 8'(i);
					default:    b = 8'($urandom);
				endcase
			end
			tx_bytes.push_back(b);
			queued_items++;
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		queued_items++;
	endtask

	// Line noise between frames; steers clear of the header byte.
	task automatic push_noise(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom);
			if (b == hdr_cfg)
				b = ~b;
			push_byte(b);
		end
	endtask

	// Sender pause: every byte taken, every field back, then the readout tail.
	task automatic wait_drained();
		while (tx_bytes.size() != 0 || rx_valid || pending_fields.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Close out a frame left half done so the next phase starts aligned.
	task automatic realign();
		if (frame_pos != 0)
			for (int i = int'(frame_pos); i < FRAME_BYTES; i++)
				push_byte(8'($urandom));
	endtask

	function automatic logic [7:0] pick_byte_value();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_config();
		if ($urandom_range(0, 1)) write_reg(REG_HEADER, pick_byte_value());
		if ($urandom_range(0, 1)) write_reg(REG_TRAILER, pick_byte_value());
		if ($urandom_range(0, 1)) write_reg(REG_LE, 8'($urandom));
		if ($urandom_range(0, 5) == 0) write_reg(REG_NONE, 8'($urandom));
	endtask

	fill_t fill_sel;
	int    pick;
	int    random_start;
	bit    pressure_done = 1'b0;

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		hdr_cfg   = HEADER_RST;
		trl_cfg   = TRAILER_RST;
		le_cfg    = 1'b0;
		frame_pos = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);

		// --- directed: reset config, noise that must be dropped, then a frame
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(TRAILER_RST);
		push_byte(8'h7F);
		push_frame(FILL_ONES, 1'b1, 0, FRAME_BYTES - 1);
		// bad trailer drops silently, next frame still lands
		push_frame(FILL_RAMP, 1'b0, 0, FRAME_BYTES - 1);
		push_frame(FILL_ZEROS, 1'b1, 0, FRAME_BYTES - 1);
		wait_drained();

		// register extremes; LE via a full-ones write (masked to 1),
		// plus a write to the unused index that must change nothing
		write_reg(REG_HEADER, 8'hFF);
		write_reg(REG_TRAILER, 8'h00);
		write_reg(REG_LE, 8'hFF);
		write_reg(REG_NONE, 8'h55);
		push_frame(FILL_RAMP, 1'b1, 0, FRAME_BYTES - 1);
		wait_drained();

		// header register moved mid-frame: frame end sees a mismatch and drops it
		push_frame(FILL_RANDOM, 1'b1, 0, 29);
		wait_drained();
		write_reg(REG_HEADER, 8'h00);
		push_frame(FILL_RANDOM, 1'b1, 30, FRAME_BYTES - 1);
		push_frame(FILL_RAMP, 1'b1, 0, FRAME_BYTES - 1);
		wait_drained();

		// byte order flipped mid-frame (0xFE masks to 0): big endian for the whole frame
		push_frame(FILL_RAMP, 1'b1, 0, 40);
		wait_drained();
		write_reg(REG_LE, 8'hFE);
		push_frame(FILL_RAMP, 1'b1, 41, FRAME_BYTES - 1);
		wait_drained();

		// --- random: mostly good frames, some bad trailers, noise and cut-off frames
		random_start = queued_items;
		while (queued_items - random_start < RANDOM_ITEMS || !pressure_done) begin
			if ($urandom_range(0, 2) == 0)
				random_config();
			realign();
			if (!pressure_done && queued_items - random_start > RANDOM_ITEMS / 2) begin
				// receiver holds off while the sender streams: both RAM slots fill
				// and rx_ready has to drop
				pressure_done = 1'b1;
				sender_steady = 1'b1;
				hold_kick++;
				for (int i = 0; i < 3; i++)
					push_frame(FILL_RANDOM, 1'b1, 0, FRAME_BYTES - 1);
				while (tx_bytes.size() != 0 || rx_valid)
					@(posedge clk);
				sender_steady = 1'b0;
			end else begin
				for (int s = $urandom_range(1, 3); s > 0; s--) begin
					pick = $urandom_range(0, 99);
					fill_sel = ($urandom_range(0, 7) == 0) ? fill_t'($urandom_range(1, 3))
					                                       : FILL_RANDOM;
					if (pick < 70)
						push_frame(fill_sel, 1'b1, 0, FRAME_BYTES - 1);
					else if (pick < 80)
						push_frame(fill_sel, 1'b0, 0, FRAME_BYTES - 1);
					else if (pick < 92)
						push_noise($urandom_range(1, 8));
					else
						// header then a short run: breaks alignment until realign
						push_frame(FILL_RANDOM, 1'b1, 0, $urandom_range(1, 58));
				end
			end
			wait_drained();
		end

		wait_drained();
		if (errors == 0 && pending_fields.size() == 0)
			$display("fixed_frame_parameter_receiver_top_test passed");
		else
			$display("fixed_frame_parameter_receiver_top_test failed");
		$finish;
	end

endmodule
